@@ design/lud_pkg.sv @@
// Shared constants and types for the LU decomposition block.
`timescale 1ns / 1ps
`default_nettype none
package lud_pkg;

    localparam int MAX_ORDER = 8;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 4;
    localparam int QUOT_W    = 49;
    localparam int STEP_W    = 6;
    localparam int REG_MATRIX_SIZE = 0;

    typedef enum logic [4:0] {
        S_LOAD, S_SC_ROW, S_SC_RD, S_SC_CMP, S_SC_END, S_SC_WAIT,
        S_COL, S_E_RD, S_E_LD, S_K_RD, S_K_MUL, S_K_ACC, S_WB, S_BEST,
        S_PIV, S_SW_RD, S_SW_W1, S_SW_W2, S_DG_RD, S_DG, S_DG_WAIT,
        S_L_RD, S_L_MUL, S_L_WR, S_EMIT, S_SING
    } ctrl_state_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD_WR, DP_BIG_CLR, DP_RD_IJ, DP_BIG_UPD, DP_SCALE_DIV,
        DP_SCALE_WR, DP_ACC_LD, DP_RD_K, DP_MUL_K, DP_ACC_SUB, DP_WB,
        DP_BEST_CLR, DP_BEST_UPD, DP_PIV, DP_RD_SWP, DP_SWP_WR1, DP_SWP_WR2,
        DP_DIAG, DP_RECIP, DP_LMUL, DP_LWR, DP_EMIT_RD, DP_SING
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
        logic             last;
    } dp_cmd_t;

    typedef struct packed {
        logic             big_zero;
        logic [IDX_W-1:0] best_row;
        logic             div_done;
    } dp_status_t;

endpackage
`default_nettype wire

@@ design/lud_div.sv @@
// Restoring divider computing 2^48 / divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lud_div
    import lud_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic [QUOT_W-1:0]      quot
);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        trial     = {rem_reg, q_reg[QUOT_W-1]};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            q_next   = {1'b1, {(QUOT_W-1){1'b0}}};
            d_next   = divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = DATA_W'(trial - {1'b0, d_reg});
                q_next   = {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_W-1:0];
                q_next   = {q_reg[QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(QUOT_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

@@ design/lud_datapath.sv @@
// Matrix memory, multiply-accumulate, pivot search and result registers.
`timescale 1ns / 1ps
`default_nettype none
module lud_datapath
    import lud_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dp_cmd_t                  cmd,
    input  wire logic signed [DATA_W-1:0] element,
    output dp_status_t                    status_o,
    output logic                          result_valid,
    output logic [IDX_W-1:0]              row,
    output logic [IDX_W-1:0]              col,
    output logic signed [DATA_W-1:0]      lu_value,
    output logic [IDX_W-1:0]              pivot_row,
    output logic                          status,
    output logic                          last
);

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] a);
        mag = a[DATA_W-1] ? DATA_W'(0) - a : a;
    endfunction

    // floor shift of a Q8.24 product, then clamp
    function automatic logic [DATA_W-1:0] qfix(input logic signed [65:0] p);
        logic signed [65:0] sh;
        sh = p >>> 24;
        if (!sh[65] && (|sh[64:DATA_W-1]))
            qfix = {1'b0, {(DATA_W-1){1'b1}}};
        else if (sh[65] && !(&sh[64:DATA_W-1]))
            qfix = {1'b1, {(DATA_W-1){1'b0}}};
        else
            qfix = sh[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] qsub(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        logic [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1])
            qsub = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            qsub = d[DATA_W-1:0];
    endfunction

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] scale_mem [MAX_ORDER];
    logic [IDX_W-1:0]  pivot_mem [MAX_ORDER];

    logic [DATA_W-1:0]        ra_reg, rb_reg;
    logic [DATA_W-1:0]        acc_reg, big_reg, recip_reg;
    logic                     piv_neg_reg;
    logic signed [65:0]       prod_reg;
    logic [63:0]              best_reg;
    logic [IDX_W-1:0]         best_row_reg;
    logic                     out_valid_reg, out_status_reg, out_last_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg, out_piv_reg;

    logic                     we, re_a, re_b;
    logic [ADDR_W-1:0]        waddr, raddr_a, raddr_b;
    logic [DATA_W-1:0]        wdata, piv_fix, scale_rd;
    logic [IDX_W-1:0]         sidx;
    logic signed [DATA_W:0]   mul_a, mul_b;
    logic                     mul_en, div_start, div_done;
    logic [DATA_W-1:0]        div_divisor;
    logic [QUOT_W-1:0]        quot;
    logic [DATA_W-1:0]        recip_mag;

    assign piv_fix   = (ra_reg == '0) ? DATA_W'(1) : ra_reg;
    assign sidx      = (cmd.op == DP_PIV) ? cmd.j : cmd.i;
    assign scale_rd  = scale_mem[sidx];
    assign recip_mag = (|quot[QUOT_W-1:DATA_W-1]) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                   : quot[DATA_W-1:0];

    always_comb
    begin
        we = 1'b0; waddr = '0; wdata = '0;
        re_a = 1'b0; raddr_a = '0; re_b = 1'b0; raddr_b = '0;
        mul_en = 1'b0; mul_a = '0; mul_b = '0;
        div_start = 1'b0; div_divisor = big_reg;
        unique case (cmd.op)
            DP_LOAD_WR:
            begin
                we = 1'b1; waddr = {cmd.i, cmd.k}; wdata = element;
            end
            DP_RD_IJ:
            begin
                re_a = 1'b1; raddr_a = {cmd.i, cmd.j};
            end
            DP_SCALE_DIV: div_start = 1'b1;
            DP_RD_K:
            begin
                re_a = 1'b1; raddr_a = {cmd.i, cmd.k};
                re_b = 1'b1; raddr_b = {cmd.k, cmd.j};
            end
            DP_MUL_K:
            begin
                mul_en = 1'b1;
                mul_a = {ra_reg[DATA_W-1], ra_reg};
                mul_b = {rb_reg[DATA_W-1], rb_reg};
            end
            DP_WB:
            begin
                we = 1'b1; waddr = {cmd.i, cmd.j}; wdata = acc_reg;
                mul_en = 1'b1;
                mul_a = {1'b0, scale_rd};
                mul_b = {1'b0, mag(acc_reg)};
            end
            DP_RD_SWP:
            begin
                re_a = 1'b1; raddr_a = {cmd.j, cmd.k};
                re_b = 1'b1; raddr_b = {best_row_reg, cmd.k};
            end
            DP_SWP_WR1:
            begin
                we = 1'b1; waddr = {cmd.j, cmd.k}; wdata = rb_reg;
            end
            DP_SWP_WR2:
            begin
                we = 1'b1; waddr = {best_row_reg, cmd.k}; wdata = ra_reg;
            end
            DP_DIAG:
            begin
                we = 1'b1; waddr = {cmd.j, cmd.j}; wdata = piv_fix;
                div_start = !cmd.last; div_divisor = mag(piv_fix);
            end
            DP_LMUL:
            begin
                mul_en = 1'b1;
                mul_a = {ra_reg[DATA_W-1], ra_reg};
                mul_b = {recip_reg[DATA_W-1], recip_reg};
            end
            DP_LWR:
            begin
                we = 1'b1; waddr = {cmd.i, cmd.j}; wdata = qfix(prod_reg);
            end
            DP_EMIT_RD:
            begin
                re_a = 1'b1; raddr_a = {cmd.i, cmd.k};
            end
            default: ;
        endcase
    end

    lud_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (div_divisor),
        .done    (div_done),
        .quot    (quot)
    );

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re_a)
            ra_reg <= mem[raddr_a];
        if (re_b)
            rb_reg <= mem[raddr_b];
        if (mul_en)
            prod_reg <= 66'(mul_a * mul_b);
        case (cmd.op)
            DP_BIG_CLR:  big_reg <= '0;
            DP_BIG_UPD:  if (mag(ra_reg) > big_reg) big_reg <= mag(ra_reg);
            DP_SCALE_WR: scale_mem[cmd.i] <= (|quot[QUOT_W-1:DATA_W]) ? '1
                                                                       : quot[DATA_W-1:0];
            DP_ACC_LD:   acc_reg <= ra_reg;
            DP_ACC_SUB:  acc_reg <= qsub(acc_reg, qfix(prod_reg));
            DP_BEST_CLR:
            begin
                best_reg     <= '0;
                best_row_reg <= cmd.j;
            end
            DP_BEST_UPD:
                if (prod_reg[63:0] >= best_reg)
                begin
                    best_reg     <= prod_reg[63:0];
                    best_row_reg <= cmd.i;
                end
            DP_PIV:
            begin
                pivot_mem[cmd.j]       <= best_row_reg;
                scale_mem[best_row_reg] <= scale_rd;
            end
            DP_DIAG:     piv_neg_reg <= piv_fix[DATA_W-1];
            DP_RECIP:    recip_reg <= piv_neg_reg ? DATA_W'(0) - recip_mag : recip_mag;
            default: ;
        endcase
        out_row_reg    <= '0;
        out_col_reg    <= '0;
        out_piv_reg    <= '0;
        out_status_reg <= 1'b0;
        out_last_reg   <= 1'b0;
        if (cmd.op == DP_EMIT_RD)
        begin
            out_row_reg  <= cmd.i;
            out_col_reg  <= cmd.k;
            out_piv_reg  <= pivot_mem[cmd.i];
            out_last_reg <= cmd.last;
        end
        else if (cmd.op == DP_SING)
        begin
            out_status_reg <= 1'b1;
            out_last_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= (cmd.op == DP_EMIT_RD) || (cmd.op == DP_SING);
    end

    assign status_o.big_zero = (big_reg == '0);
    assign status_o.best_row = best_row_reg;
    assign status_o.div_done = div_done;

    assign result_valid = out_valid_reg;
    assign row          = out_row_reg;
    assign col          = out_col_reg;
    assign lu_value     = out_status_reg ? '0 : ra_reg;
    assign pivot_row    = out_piv_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;

endmodule
`default_nettype wire

@@ design/lud_ctrl.sv @@
// Sequencer for load, row scaling, Crout elimination and result readout.
`timescale 1ns / 1ps
`default_nettype none
module lud_ctrl
    import lud_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              cfg_wr,
    input  wire logic [SIZE_W-1:0] size,
    input  wire dp_status_t        st,
    output dp_cmd_t                cmd,
    output logic                   busy
);

    ctrl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0] lr_reg, lr_next, lc_reg, lc_next;
    logic [SIZE_W-1:0] n;
    logic [SIZE_W-1:0] i1, j1, k1, lr1, lc1;
    logic [IDX_W-1:0] kmax;
    logic             n_last_j;

    always_comb
    begin
        if (size == '0)
            n = SIZE_W'(1);
        else if (size > SIZE_W'(MAX_ORDER))
            n = SIZE_W'(MAX_ORDER);
        else
            n = size;
    end

    assign i1  = {1'b0, i_reg} + SIZE_W'(1);
    assign j1  = {1'b0, j_reg} + SIZE_W'(1);
    assign k1  = {1'b0, k_reg} + SIZE_W'(1);
    assign lr1 = {1'b0, lr_reg} + SIZE_W'(1);
    assign lc1 = {1'b0, lc_reg} + SIZE_W'(1);
    assign kmax = (i_reg < j_reg) ? i_reg : j_reg;
    assign n_last_j = (j1 == n);

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg;
        lr_next = lr_reg; lc_next = lc_reg;
        cmd.op = DP_NOP; cmd.i = i_reg; cmd.j = j_reg; cmd.k = k_reg; cmd.last = 1'b0;
        unique case (state_reg)
            S_LOAD:
                if (cfg_wr)
                begin
                    lr_next = '0;
                    lc_next = '0;
                end
                else if (start)
                begin
                    cmd.op = DP_LOAD_WR; cmd.i = lr_reg; cmd.k = lc_reg;
                    if (lc1 == n)
                    begin
                        lc_next = '0;
                        if (lr1 == n)
                        begin
                            lr_next = '0;
                            i_next = '0;
                            state_next = S_SC_ROW;
                        end
                        else
                            lr_next = lr1[IDX_W-1:0];
                    end
                    else
                        lc_next = lc1[IDX_W-1:0];
                end
            S_SC_ROW:
            begin
                cmd.op = DP_BIG_CLR; k_next = '0; state_next = S_SC_RD;
            end
            S_SC_RD:
            begin
                cmd.op = DP_RD_IJ; cmd.j = k_reg; state_next = S_SC_CMP;
            end
            S_SC_CMP:
            begin
                cmd.op = DP_BIG_UPD;
                if (k1 == n)
                    state_next = S_SC_END;
                else
                begin
                    k_next = k1[IDX_W-1:0];
                    state_next = S_SC_RD;
                end
            end
            S_SC_END:
                if (st.big_zero)
                    state_next = S_SING;
                else
                begin
                    cmd.op = DP_SCALE_DIV; state_next = S_SC_WAIT;
                end
            S_SC_WAIT:
                if (st.div_done)
                begin
                    cmd.op = DP_SCALE_WR;
                    if (i1 == n)
                    begin
                        j_next = '0;
                        state_next = S_COL;
                    end
                    else
                    begin
                        i_next = i1[IDX_W-1:0];
                        state_next = S_SC_ROW;
                    end
                end
            S_COL:
            begin
                cmd.op = DP_BEST_CLR; i_next = '0; state_next = S_E_RD;
            end
            S_E_RD:
            begin
                cmd.op = DP_RD_IJ; k_next = '0; state_next = S_E_LD;
            end
            S_E_LD:
            begin
                cmd.op = DP_ACC_LD;
                state_next = (kmax != '0) ? S_K_RD : S_WB;
            end
            S_K_RD:
            begin
                cmd.op = DP_RD_K; state_next = S_K_MUL;
            end
            S_K_MUL:
            begin
                cmd.op = DP_MUL_K; state_next = S_K_ACC;
            end
            S_K_ACC:
            begin
                cmd.op = DP_ACC_SUB;
                if (k1 == {1'b0, kmax})
                    state_next = S_WB;
                else
                begin
                    k_next = k1[IDX_W-1:0];
                    state_next = S_K_RD;
                end
            end
            S_WB, S_BEST:
            begin
                cmd.op = (state_reg == S_WB) ? DP_WB : DP_BEST_UPD;
                if (state_reg == S_WB && i_reg >= j_reg)
                    state_next = S_BEST;
                else if (i1 == n)
                    state_next = S_PIV;
                else
                begin
                    i_next = i1[IDX_W-1:0];
                    state_next = S_E_RD;
                end
            end
            S_PIV:
            begin
                cmd.op = DP_PIV; k_next = '0;
                state_next = (st.best_row != j_reg) ? S_SW_RD : S_DG_RD;
            end
            S_SW_RD:
            begin
                cmd.op = DP_RD_SWP; state_next = S_SW_W1;
            end
            S_SW_W1:
            begin
                cmd.op = DP_SWP_WR1; state_next = S_SW_W2;
            end
            S_SW_W2:
            begin
                cmd.op = DP_SWP_WR2;
                if (k1 == n)
                    state_next = S_DG_RD;
                else
                begin
                    k_next = k1[IDX_W-1:0];
                    state_next = S_SW_RD;
                end
            end
            S_DG_RD:
            begin
                cmd.op = DP_RD_IJ; cmd.i = j_reg; state_next = S_DG;
            end
            S_DG:
            begin
                cmd.op = DP_DIAG; cmd.last = n_last_j;
                if (n_last_j)
                begin
                    i_next = '0; k_next = '0;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_DG_WAIT;
            end
            S_DG_WAIT:
                if (st.div_done)
                begin
                    cmd.op = DP_RECIP;
                    i_next = j1[IDX_W-1:0];
                    state_next = S_L_RD;
                end
            S_L_RD:
            begin
                cmd.op = DP_RD_IJ; state_next = S_L_MUL;
            end
            S_L_MUL:
            begin
                cmd.op = DP_LMUL; state_next = S_L_WR;
            end
            S_L_WR:
            begin
                cmd.op = DP_LWR;
                if (i1 == n)
                begin
                    j_next = j1[IDX_W-1:0];
                    state_next = S_COL;
                end
                else
                begin
                    i_next = i1[IDX_W-1:0];
                    state_next = S_L_RD;
                end
            end
            S_EMIT:
            begin
                cmd.op = DP_EMIT_RD;
                cmd.last = (i1 == n) && (k1 == n);
                if (k1 == n)
                begin
                    k_next = '0;
                    if (i1 == n)
                        state_next = S_LOAD;
                    else
                        i_next = i1[IDX_W-1:0];
                end
                else
                    k_next = k1[IDX_W-1:0];
            end
            S_SING:
            begin
                cmd.op = DP_SING; state_next = S_LOAD;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            lr_reg    <= '0;
            lc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lr_reg    <= lr_next;
            lc_reg    <= lc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    assign busy = (state_reg != S_LOAD);

endmodule
`default_nettype wire

@@ design/lu_decompose_partial_pivot.sv @@
// Top level of the LU decomposition block with its register port.
`timescale 1ns / 1ps
`default_nettype none
// Load an n-by-n Q8.24 matrix one element per request (start high, busy low),
// row-major; n comes from matrix_size at byte address 0, and writing it drops a
// partial load. After the last element busy rises while one shared multiplier
// and one restoring divider work the Crout elimination through a single-write,
// dual-read matrix memory: a divide per row scale and per pivot reciprocal, plus
// a multiply-accumulate per inner-product term and a read and two writes per
// swapped element. Results then stream one per cycle on result_valid, row-major,
// with last on the final one; a row of zeros gives a single result with status
// set. The receiver cannot stall, so take each result in the cycle it is shown.
module lu_decompose_partial_pivot
    import lud_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [2:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] element,
    output logic                          result_valid,
    output logic [IDX_W-1:0]              row,
    output logic [IDX_W-1:0]              col,
    output logic signed [DATA_W-1:0]      lu_value,
    output logic [IDX_W-1:0]              pivot_row,
    output logic                          status,
    output logic                          last
);

    logic [SIZE_W-1:0] size_reg;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_status_t        st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_MATRIX_SIZE));
    assign prdata = (paddr[2] == 1'(REG_MATRIX_SIZE)) ? {28'd0, size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_W'(MAX_ORDER);
        else if (cfg_wr)
            size_reg <= pwdata[SIZE_W-1:0];
    end

    lud_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_wr (cfg_wr),
        .size   (size_reg),
        .st     (st),
        .cmd    (cmd),
        .busy   (busy)
    );

    lud_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .element      (element),
        .status_o     (st),
        .result_valid (result_valid),
        .row          (row),
        .col          (col),
        .lu_value     (lu_value),
        .pivot_row    (pivot_row),
        .status       (status),
        .last         (last)
    );

`ifndef SYNTHESIS
    a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> last && row == '0 && col == '0)
        else $error("singular result not final");
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !status && last |-> row == col)
        else $error("final result off the diagonal");
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a run");
    a_busy_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("run began without a request");
`endif

endmodule
`default_nettype wire

@@ dv/lu_decompose_partial_pivot_tb.sv @@
// Self-checking testbench for the LU decomposition block with partial pivoting.
`timescale 1ns / 1ps
module lu_decompose_partial_pivot_tb;
    import lud_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DATA_W-1:0] val;
        logic [IDX_W-1:0]        piv;
        logic                    status;
        logic                    last;
    } lu_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [2:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [DATA_W-1:0] element = '0;
    logic                     result_valid;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] lu_value;
    logic [IDX_W-1:0]         pivot_row;
    logic                     status;
    logic                     last;

    // Predictor state
    logic [SIZE_W-1:0]        size_reg = 4'd8;
    int unsigned              load_cnt = 0;
    logic signed [31:0]       lu_mat [DEPTH];
    logic [31:0]              scale_of [MAX_ORDER];
    logic [IDX_W-1:0]         piv_of [MAX_ORDER];
    lu_result_t               lu_expected [$];
    int                       err_cnt = 0;
    bit                       gaps_on = 1'b1;

    lu_decompose_partial_pivot dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .element(element), .result_valid(result_valid),
        .row(row), .col(col), .lu_value(lu_value), .pivot_row(pivot_row),
        .status(status), .last(last)
    );

    always #6 clk = ~clk;

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat32(p >>> 24);
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return sat32(longint'(a) - longint'(b));
    endfunction

    function automatic logic [31:0] mag(input logic signed [31:0] a);
        return a < 0 ? 32'd0 - a : a;
    endfunction

    function automatic int unsigned order_now();
        if (size_reg < 1) return 1;
        if (size_reg > MAX_ORDER) return MAX_ORDER;
        return size_reg;
    endfunction

    // In-place Crout elimination; returns 0 when some row is all zero.
    function automatic bit crout_decompose(input int unsigned n);
        logic [31:0] big, pm;
        longint unsigned s, best, w, q;
        logic signed [31:0] sum, t, recip;
        int unsigned best_row;
        for (int i = 0; i < n; i++) begin
            big = 0;
            for (int j = 0; j < n; j++)
                if (mag(lu_mat[i*8+j]) > big) big = mag(lu_mat[i*8+j]);
            if (big == 0) return 0;
            s = (64'd1 << 48) / big;
            if (s > 64'hffffffff) s = 64'hffffffff;
            scale_of[i] = s[31:0];
        end
        for (int j = 0; j < n; j++) begin
            best_row = j;
            best = 0;
            for (int i = 0; i < j; i++) begin
                sum = lu_mat[i*8+j];
                for (int k = 0; k < i; k++)
                    sum = fx_sub(sum, fx_mul(lu_mat[i*8+k], lu_mat[k*8+j]));
                lu_mat[i*8+j] = sum;
            end
            for (int i = j; i < n; i++) begin
                sum = lu_mat[i*8+j];
                for (int k = 0; k < j; k++)
                    sum = fx_sub(sum, fx_mul(lu_mat[i*8+k], lu_mat[k*8+j]));
                lu_mat[i*8+j] = sum;
                w = longint'(scale_of[i]) * longint'(mag(sum));
                if (w >= best) begin
                    best = w;
                    best_row = i;
                end
            end
            piv_of[j] = best_row[IDX_W-1:0];
            if (best_row != j) begin
                for (int k = 0; k < n; k++) begin
                    t = lu_mat[j*8+k];
                    lu_mat[j*8+k] = lu_mat[best_row*8+k];
                    lu_mat[best_row*8+k] = t;
                end
                scale_of[best_row] = scale_of[j];
            end
            // zero pivot becomes one LSB
            if (lu_mat[j*8+j] == 0) lu_mat[j*8+j] = 1;
            if (j != n - 1) begin
                pm = mag(lu_mat[j*8+j]);
                q = (64'd1 << 48) / pm;
                if (q > 64'h7fffffff) q = 64'h7fffffff;
                recip = lu_mat[j*8+j] < 0 ? -q[31:0] : q[31:0];
                for (int i = j + 1; i < n; i++)
                    lu_mat[i*8+j] = fx_mul(lu_mat[i*8+j], recip);
            end
        end
        return 1;
    endfunction

    task automatic predict_element(input logic signed [31:0] v);
        int unsigned n;
        lu_result_t r;
        n = order_now();
        if (load_cnt >= n * n) load_cnt = 0;
        lu_mat[(load_cnt / n) * 8 + (load_cnt % n)] = v;
        load_cnt++;
        if (load_cnt < n * n) return;
        load_cnt = 0;
        if (!crout_decompose(n)) begin
            r = '0;
            r.status = 1'b1;
            r.last = 1'b1;
            lu_expected.push_back(r);
            return;
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                r.row = IDX_W'(i);
                r.col = IDX_W'(j);
                r.val = lu_mat[i*8+j];
                r.piv = piv_of[i];
                r.status = 1'b0;
                r.last = (i == n - 1 && j == n - 1);
                lu_expected.push_back(r);
            end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    always @(posedge clk) begin
        lu_result_t e;
        if (rst_n && result_valid) begin
            if (lu_expected.size() == 0) begin
                report_mismatch("unexpected result", lu_value, 0);
            end else begin
                e = lu_expected.pop_front();
                if (row !== e.row) report_mismatch("row", row, e.row);
                if (col !== e.col) report_mismatch("col", col, e.col);
                if (lu_value !== e.val) report_mismatch("lu_value", lu_value, e.val);
                if (pivot_row !== e.piv) report_mismatch("pivot_row", pivot_row, e.piv);
                if (status !== e.status) report_mismatch("status", status, e.status);
                if (last !== e.last) report_mismatch("last", last, e.last);
            end
        end
    end

    task automatic send_element(input logic signed [31:0] v);
        start <= 1'b1;
        element <= v;
        do @(posedge clk); while (busy);
        predict_element(v);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (lu_expected.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        start <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(REG_MATRIX_SIZE * 4)) begin
            size_reg = data[SIZE_W-1:0];
            load_cnt = 0;
        end
    endtask

    task automatic set_order(input logic [31:0] n);
        drain();
        write_reg(3'(REG_MATRIX_SIZE * 4), n);
    endtask

    task automatic test_order_one();
        set_order(1);
        send_element(0);
        send_element(32'sh01000000);
        send_element(32'sh80000000);
        send_element(32'sh7fffffff);
        set_order(0);
        send_element(-32'sd5);
    endtask

    task automatic test_pivot_cases();
        set_order(2);
        // tied rows: later row wins, then the second pivot is zero
        send_element(32'sh01000000); send_element(32'sh02000000);
        send_element(32'sh01000000); send_element(32'sh02000000);
        send_element(0); send_element(32'sh01000000);
        send_element(32'sh01000000); send_element(0);
        send_element(32'sh80000000); send_element(32'sh7fffffff);
        send_element(32'sh7fffffff); send_element(32'sh80000000);
    endtask

    task automatic test_size_write_mid_load();
        set_order(3);
        repeat (4) send_element($urandom);
        start <= 1'b0;
        @(posedge clk);
        write_reg(3'(REG_MATRIX_SIZE * 4), 2);
        repeat (4) send_element($urandom);
        // a write to an unused address leaves the size alone
        set_order(2);
        drain();
        write_reg(3'd4, 5);
    endtask

    function automatic logic signed [31:0] pick_element();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 0;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
        endcase
    endfunction

    task automatic test_random_matrices();
        int sent, n, zrow;
        logic [31:0] sz;
        sent = 0;
        while (sent < 235) begin
            if (sent > 195) gaps_on = 1'b0;
            case ($urandom_range(0, 9))
                0: sz = 8;
                1: sz = $urandom_range(9, 15);
                2: sz = 0;
                default: sz = $urandom_range(1, 4);
            endcase
            set_order(sz);
            n = order_now();
            zrow = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
            for (int i = 0; i < n * n; i++) begin
                send_element((i / n == zrow) ? 32'sd0 : pick_element());
                sent++;
            end
            // broken load now and then
            if ($urandom_range(0, 7) == 0) begin
                drain();
                repeat ($urandom_range(1, n * n - 1 + (n == 1))) begin
                    send_element(pick_element());
                    sent++;
                end
                drain();
                write_reg(3'(REG_MATRIX_SIZE * 4), sz);
            end
        end
        start <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_order_one();
        test_pivot_cases();
        test_size_write_mid_load();
        test_random_matrices();
        drain();
        repeat (20) @(posedge clk);
        if (err_cnt == 0 && lu_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #8ms;
        $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
design/lud_pkg.sv
design/lud_div.sv
design/lud_datapath.sv
design/lud_ctrl.sv
design/lu_decompose_partial_pivot.sv
dv/lu_decompose_partial_pivot_tb.sv
